// ===== design/gcm_pkg.sv =====
package gcm_pkg;

  // Configuration port
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [53:0] cfg_data_t;
  typedef logic [53:0] thr_t;

  localparam cfg_idx_t CFG_GENOME_LENGTH = 2'd0;
  localparam cfg_idx_t CFG_CX_THRESHOLD  = 2'd1;
  localparam cfg_idx_t CFG_MUT_THRESHOLD = 2'd2;

  localparam logic [6:0] GENOME_LENGTH_RST = 7'd64;
  localparam thr_t       CX_THRESHOLD_RST  = 54'd6305039478318694;  // 0.7
  localparam thr_t       MUT_THRESHOLD_RST = 54'd140737488355328;   // 1/64

  // Longest genome the 64-bit datapath holds
  localparam logic [6:0] MAX_GENES = 7'd64;

  // Operation codes
  localparam logic [1:0] OP_SINGLE  = 2'd0;
  localparam logic [1:0] OP_TWO     = 2'd1;
  localparam logic [1:0] OP_UNIFORM = 2'd2;
  localparam logic [1:0] OP_MUTATE  = 2'd3;

  // Generator constants
  localparam logic [63:0] GEN_RST = 64'd314159;
  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
  localparam logic [63:0] MIX_K1  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_K2  = 64'hc4ceb9fe1a85ec53;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] parent_a;
    logic [63:0] parent_b;
    logic        load_seed;
    logic [63:0] seed_value;
  } gcm_in_t;

  typedef struct packed {
    logic [63:0] child_a;
    logic [63:0] child_b;
    logic [63:0] seed_out;
  } gcm_out_t;

  // Generator control from the sequencer
  typedef struct packed {
    logic load;
    logic start;
  } gcm_rng_req_t;

endpackage

// ===== design/genome_crossover_mutation.sv =====
// Each generator draw forms three 64-bit products, each in three passes through the
//   shared 32x32 multiplier plus a finish step, and then hands the draw off.
// Uniform and mutate take one draw per gene for genome length L; single-point takes one
//   draw, plus a second draw and a 64-step serial remainder when it crosses; two-point
//   takes two draws and two 64-step serial remainders.
// Throughput: one request at a time; the next request is taken once the result is
//   registered, even while that result waits on out_ready.
// Reset: synchronous active-low; generator state 314159, registers to defaults.
module genome_crossover_mutation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gcm_pkg::gcm_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gcm_pkg::gcm_out_t  out_data,
  input  logic               cfg_we,
  input  gcm_pkg::cfg_idx_t  cfg_idx,
  input  gcm_pkg::cfg_data_t cfg_wdata
);
  import gcm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DRAW = 5'b00010,
    S_WAIT = 5'b00100,
    S_MOD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t       state_r;
  logic [6:0]   len_cfg_r;
  thr_t         cx_thr_r;
  thr_t         mut_thr_r;
  logic [1:0]   op_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  ca_r;
  logic [63:0]  cb_r;
  logic [6:0]   len_r;
  logic [5:0]   idx_r;
  logic         phase_r;
  logic [5:0]   p1_r;
  logic         out_valid_r;
  gcm_out_t     out_r;

  logic [6:0]   len_eff;
  logic [63:0]  gmask;
  logic         accept;
  logic         out_load;
  gcm_rng_req_t rng_req;
  logic [63:0]  rng_draw;
  logic         rng_done;
  logic [63:0]  rng_state;
  logic         mod_start;
  logic [6:0]   mod_div;
  logic [5:0]   mod_rem;
  logic         mod_done;
  logic [53:0]  draw_fix;
  logic         cx_pass;
  logic         mut_pass;
  logic         swap;
  logic         last_bit;
  logic [63:0]  pt_mask;
  logic [5:0]   span_lo;
  logic [5:0]   span_hi;
  logic [63:0]  span;

  function automatic logic [63:0] low_mask(input logic [6:0] n);
    logic [63:0] m;
    for (int i = 0; i < 64; i++) begin
      m[i] = (7'(i) < n);
    end
    return m;
  endfunction

  // Effective genome length and mask
  always_comb begin
    if (len_cfg_r < 7'd2) begin
      len_eff = 7'd2;
    end else if (len_cfg_r > MAX_GENES) begin
      len_eff = MAX_GENES;
    end else begin
      len_eff = len_cfg_r;
    end
    gmask = low_mask(len_eff);
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Generator
  assign rng_req = '{load: accept && in_data.load_seed, start: (state_r == S_DRAW)};

  gcm_rng u_rng (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rng_req),
    .seed  (in_data.seed_value),
    .draw  (rng_draw),
    .done  (rng_done),
    .state (rng_state)
  );

  // Remainder of a draw by L or L-1
  assign mod_start = (state_r == S_WAIT) && rng_done &&
                     ((op_r == OP_TWO) || ((op_r == OP_SINGLE) && phase_r));
  assign mod_div   = (op_r == OP_SINGLE) ? (len_r - 7'd1) : len_r;

  gcm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (rng_draw),
    .divisor  (mod_div),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  // Draw tests and crossover masks
  always_comb begin
    draw_fix = {1'b0, rng_draw[63:11]};
    cx_pass  = (draw_fix < cx_thr_r);
    mut_pass = (draw_fix < mut_thr_r);
    swap     = !rng_draw[63];
    last_bit = ({1'b0, idx_r} == (len_r - 7'd1));
    pt_mask  = low_mask(7'(mod_rem) + 7'd1);
    if (p1_r > mod_rem) begin
      span_lo = mod_rem;
      span_hi = p1_r;
    end else begin
      span_lo = p1_r;
      span_hi = mod_rem;
    end
    span = low_mask(7'(span_hi) + 7'd1) & ~low_mask(7'(span_lo));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= GENOME_LENGTH_RST;
      cx_thr_r  <= CX_THRESHOLD_RST;
      mut_thr_r <= MUT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GENOME_LENGTH: len_cfg_r <= cfg_wdata[6:0];
        CFG_CX_THRESHOLD:  cx_thr_r  <= cfg_wdata;
        CFG_MUT_THRESHOLD: mut_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      // result register: load a new result or drop the one taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_data.op;
            a_r     <= in_data.parent_a & gmask;
            b_r     <= in_data.parent_b & gmask;
            ca_r    <= in_data.parent_a & gmask;
            cb_r    <= in_data.parent_b & gmask;
            len_r   <= len_eff;
            idx_r   <= '0;
            phase_r <= 1'b0;
            state_r <= S_DRAW;
          end
        end
        S_DRAW: state_r <= S_WAIT;
        S_WAIT: begin
          if (rng_done) begin
            unique case (op_r)
              OP_SINGLE: begin
                if (phase_r) begin
                  state_r <= S_MOD;
                end else if (cx_pass) begin
                  phase_r <= 1'b1;
                  state_r <= S_DRAW;
                end else begin
                  state_r <= S_OUT;
                end
              end
              OP_TWO: state_r <= S_MOD;
              OP_UNIFORM: begin
                if (swap) begin
                  ca_r[idx_r] <= b_r[idx_r];
                  cb_r[idx_r] <= a_r[idx_r];
                end
                idx_r   <= idx_r + 6'd1;
                state_r <= last_bit ? S_OUT : S_DRAW;
              end
              default: begin
                if (mut_pass) begin
                  ca_r[idx_r] <= ~a_r[idx_r];
                end
                idx_r   <= idx_r + 6'd1;
                state_r <= last_bit ? S_OUT : S_DRAW;
              end
            endcase
          end
        end
        S_MOD: begin
          if (mod_done) begin
            if (op_r == OP_SINGLE) begin
              ca_r    <= (a_r & pt_mask) | (b_r & ~pt_mask);
              cb_r    <= (b_r & pt_mask) | (a_r & ~pt_mask);
              state_r <= S_OUT;
            end else if (!phase_r) begin
              p1_r    <= mod_rem;
              phase_r <= 1'b1;
              state_r <= S_DRAW;
            end else begin
              ca_r    <= (a_r & ~span) | (b_r & span);
              cb_r    <= (b_r & ~span) | (a_r & span);
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_r.child_a  <= ca_r;
            out_r.child_b  <= cb_r;
            out_r.seed_out <= rng_state;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_rng_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    rng_done |-> (state_r == S_WAIT))
    else $error("generator finished outside its wait state");

  a_mod_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("remainder finished outside its wait state");

  a_mod_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mod_start |-> (mod_div != 7'd0))
    else $error("remainder started with zero divisor");

  a_seed_out_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_r.seed_out == rng_state))
    else $error("result seed differs from generator state");
`endif

endmodule

// ===== design/gcm_mod.sv =====
module gcm_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [6:0]  divisor,
  output logic [5:0]  rem,
  output logic        done
);
  import gcm_pkg::*;

  logic [63:0] quo_r;
  logic [6:0]  rem_r;
  logic [6:0]  div_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [7:0]  trial;
  logic [6:0]  rem_nxt;

  // One restoring remainder step per cycle, MSB first
  always_comb begin
    trial = {rem_r, quo_r[63]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = 7'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[62:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder is below a divisor of at most 64
  assign rem  = rem_r[5:0];
  assign done = done_r;

endmodule

// ===== design/gcm_rng.sv =====
module gcm_rng (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gcm_pkg::gcm_rng_req_t req,
  input  logic [63:0]           seed,
  output logic [63:0]           draw,
  output logic                  done,
  output logic [63:0]           state
);
  import gcm_pkg::*;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_MUL  = 3'b010,
    R_FIN  = 3'b100
  } rng_state_t;

  localparam logic [1:0] SEL_LCG = 2'd0;
  localparam logic [1:0] SEL_K1  = 2'd1;
  localparam logic [1:0] SEL_K2  = 2'd2;

  rng_state_t  fsm_r;
  logic [63:0] gen_r;
  logic [63:0] x_r;
  logic [63:0] acc_r;
  logic [63:0] draw_r;
  logic [1:0]  step_r;
  logic [1:0]  sel_r;
  logic        done_r;

  logic [63:0] k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc_nxt;
  logic [63:0] lcg_s;

  function automatic logic [63:0] mix(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

  // Constant for the current product
  always_comb begin
    unique case (sel_r)
      SEL_LCG: k = LCG_MUL;
      SEL_K1:  k = MIX_K1;
      default: k = MIX_K2;
    endcase
  end

  // Shared 32x32 multiplier: low 64 bits of a 64x64 product in three passes
  always_comb begin
    unique case (step_r)
      2'd0:    begin mul_a = x_r[31:0];  mul_b = k[31:0];  end
      2'd1:    begin mul_a = x_r[63:32]; mul_b = k[31:0];  end
      default: begin mul_a = x_r[31:0];  mul_b = k[63:32]; end
    endcase
    prod = mul_a * mul_b;
    if (step_r == 2'd0) begin
      acc_nxt = prod;
    end else begin
      acc_nxt = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
    end
    lcg_s = acc_r + LCG_ADD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r  <= R_IDLE;
      gen_r  <= GEN_RST;
      step_r <= '0;
      sel_r  <= SEL_LCG;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (fsm_r)
        R_IDLE: begin
          if (req.load) begin
            gen_r <= seed;
          end
          if (req.start) begin
            x_r    <= gen_r;
            sel_r  <= SEL_LCG;
            step_r <= '0;
            fsm_r  <= R_MUL;
          end
        end
        R_MUL: begin
          acc_r <= acc_nxt;
          if (step_r == 2'd2) begin
            step_r <= '0;
            fsm_r  <= R_FIN;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        R_FIN: begin
          unique case (sel_r)
            SEL_LCG: begin
              gen_r <= lcg_s;
              x_r   <= mix(lcg_s);
              sel_r <= SEL_K1;
              fsm_r <= R_MUL;
            end
            SEL_K1: begin
              x_r   <= mix(acc_r);
              sel_r <= SEL_K2;
              fsm_r <= R_MUL;
            end
            default: begin
              draw_r <= mix(acc_r);
              done_r <= 1'b1;
              fsm_r  <= R_IDLE;
            end
          endcase
        end
        default: fsm_r <= R_IDLE;
      endcase
    end
  end

  assign draw  = draw_r;
  assign done  = done_r;
  assign state = gen_r;

endmodule

// ===== dv/tb.sv =====
module tb;
  import gcm_pkg::*;

  // Generator constants and register defaults, taken from the block's definition
  localparam logic [63:0] K_MUL = 64'd6364136223846793005;
  localparam logic [63:0] K_ADD = 64'd1442695040888963407;
  localparam logic [63:0] K_MIX1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] K_MIX2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] SEED_RST = 64'd314159;
  localparam logic [6:0]  RST_LEN = 7'd64;
  localparam thr_t RCX  = 54'd6305039478318694;  // 0.7
  localparam thr_t RMUT = 54'd140737488355328;   // 1/64
  localparam thr_t ONE   = thr_t'(1) << 53;       // probability 1.0
  localparam thr_t TNEAR = ONE - thr_t'(1);
  localparam thr_t TMAX  = '1;

  // Genome patterns for the directed list
  localparam logic [63:0] Z64 = '0;
  localparam logic [63:0] F64 = '1;
  localparam logic [63:0] PA  = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] PB  = 64'hFEDC_BA98_7654_3210;

  localparam int NUM_DIR = 25;
  localparam int NUM_RANDOM = 1850;

  typedef struct packed {
    logic [6:0]  glen;
    thr_t        cx;
    thr_t        mut;
    gcm_in_t     req;
    logic        known;  // children typed in below
    logic [63:0] ca;
    logic [63:0] cb;
  } dir_row_t;

  // Directed list: register setting, request, and children where they are obvious
  dir_row_t dir_rows [NUM_DIR] = '{
    // defaults straight out of reset
    '{RST_LEN, RCX, RMUT, '{OP_SINGLE,  F64, Z64, 1'b0, Z64}, 1'b0, Z64, Z64},
    '{RST_LEN, RCX, RMUT, '{OP_TWO,     Z64, F64, 1'b0, Z64}, 1'b0, Z64, Z64},
    '{RST_LEN, RCX, RMUT, '{OP_UNIFORM, F64, Z64, 1'b0, Z64}, 1'b0, Z64, Z64},
    '{RST_LEN, RCX, RMUT, '{OP_MUTATE,  PA,  PB,  1'b0, Z64}, 1'b0, Z64, Z64},
    '{RST_LEN, RCX, RMUT, '{OP_MUTATE,  PB,  PA,  1'b1, Z64}, 1'b0, Z64, Z64},
    '{RST_LEN, RCX, RMUT, '{OP_SINGLE,  PA,  PB,  1'b1, F64}, 1'b0, Z64, Z64},
    // zero thresholds: never crosses, never flips
    '{7'd64, '0, '0, '{OP_SINGLE, PA, PB, 1'b0, Z64}, 1'b1, PA, PB},
    '{7'd64, '0, '0, '{OP_MUTATE, PB, PA, 1'b0, Z64}, 1'b1, PB, PA},
    // thresholds at and above 1.0: always passes
    '{7'd64, ONE, ONE, '{OP_MUTATE, PA, F64, 1'b0, Z64}, 1'b1, PB, F64},
    '{7'd64, ONE, ONE, '{OP_SINGLE, PA, Z64, 1'b0, Z64}, 1'b0, Z64, Z64},
    '{7'd64, TMAX, TMAX, '{OP_MUTATE, Z64, PA, 1'b0, Z64}, 1'b1, F64, PA},
    '{7'd64, TMAX, TMAX, '{OP_UNIFORM, PA, PB, 1'b1, PA}, 1'b0, Z64, Z64},
    // shortest genome: single-point can only cut at bit 1
    '{7'd2, ONE, '0, '{OP_SINGLE,  F64, Z64, 1'b0, Z64}, 1'b1, 64'd1, 64'd2},
    '{7'd2, ONE, '0, '{OP_TWO,     F64, Z64, 1'b0, Z64}, 1'b0, Z64, Z64},
    '{7'd2, ONE, '0, '{OP_UNIFORM, F64, Z64, 1'b0, Z64}, 1'b0, Z64, Z64},
    '{7'd2, ONE, '0, '{OP_MUTATE,  F64, PA,  1'b0, Z64}, 1'b1, 64'd3, 64'd3},
    // lengths outside 2..64 clamp; bits above the genome read as zero
    '{7'd0,   '0, '0,  '{OP_MUTATE, F64, F64, 1'b0, Z64}, 1'b1, 64'd3, 64'd3},
    '{7'd1,   '0, ONE, '{OP_MUTATE, Z64, F64, 1'b0, Z64}, 1'b1, 64'd3, 64'd3},
    '{7'd127, '0, '0,  '{OP_MUTATE, F64, PA,  1'b0, Z64}, 1'b1, F64, PA},
    '{7'd65, ONE, ONE, '{OP_TWO, PA, PB, 1'b0, Z64}, 1'b0, Z64, Z64},
    // odd length, reseeded to the reset value
    '{7'd33, RCX, RMUT, '{OP_UNIFORM, PA, PB,  1'b1, SEED_RST}, 1'b0, Z64, Z64},
    '{7'd33, RCX, RMUT, '{OP_SINGLE,  PA, PB,  1'b0, Z64}, 1'b0, Z64, Z64},
    '{7'd33, RCX, RMUT, '{OP_TWO,     PA, F64, 1'b0, Z64}, 1'b0, Z64, Z64},
    // thresholds one step off the ends
    '{7'd63, TNEAR, thr_t'(1), '{OP_MUTATE, PA,  PB,  1'b0, Z64}, 1'b0, Z64, Z64},
    '{7'd63, TNEAR, thr_t'(1), '{OP_SINGLE, F64, Z64, 1'b0, Z64}, 1'b0, Z64, Z64}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gcm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gcm_out_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_GENOME_LENGTH;
  cfg_data_t cfg_wdata = '0;

  // Predictor copy of the block's state and registers
  logic [63:0] rng_state = SEED_RST;
  logic [6:0]  len_reg = RST_LEN;
  thr_t        cx_thr = RCX;
  thr_t        mut_thr = RMUT;

  gcm_out_t pending_children [$];
  int fail_count = 0;
  int results_seen = 0;
  int burst_left = 0;
  int ready_left = 0;
  int cfg_sets = 0;
  int op_seen [4] = '{0, 0, 0, 0};

  genome_crossover_mutation DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // One generator step: LCG advance, then the 64-bit mix finalizer
  function automatic logic [63:0] next_draw();
    logic [63:0] z;
    rng_state = rng_state * K_MUL + K_ADD;
    z = rng_state ^ (rng_state >> 33);
    z = z * K_MIX1;
    z = z ^ (z >> 33);
    z = z * K_MIX2;
    return z ^ (z >> 33);
  endfunction

  function automatic logic [63:0] low_bits(input int unsigned n);
    return (n >= 64) ? '1 : (64'd1 << n) - 64'd1;
  endfunction

  // Children and generator state for one request
  function automatic gcm_out_t recombine(input gcm_in_t r);
    int unsigned len, p1, p2, t;
    logic [63:0] gm, a, b, ca, cb, lo, span, d;
    gcm_out_t o;
    if (len_reg < 7'd2) len = 2;
    else if (len_reg > 7'd64) len = 64;
    else len = 32'(len_reg);
    gm = low_bits(len);
    a = r.parent_a & gm;
    b = r.parent_b & gm;
    ca = a;
    cb = b;
    if (r.load_seed) rng_state = r.seed_value;
    case (r.op)
      OP_SINGLE: begin
        d = next_draw();
        if ((d >> 11) < 64'(cx_thr)) begin
          p1 = 32'(next_draw() % 64'(len - 1)) + 1;
          lo = low_bits(p1);
          ca = (a & lo) | (b & ~lo);
          cb = (b & lo) | (a & ~lo);
        end
      end
      OP_TWO: begin
        p1 = 32'(next_draw() % 64'(len));
        p2 = 32'(next_draw() % 64'(len));
        if (p1 > p2) begin
          t = p1;
          p1 = p2;
          p2 = t;
        end
        span = low_bits(p2 + 1) & ~low_bits(p1);
        ca = (a & ~span) | (b & span);
        cb = (b & ~span) | (a & span);
      end
      OP_UNIFORM: begin
        // top bit clear means draw below one half: swap the gene
        for (int i = 0; i < len; i++) begin
          d = next_draw();
          if (!d[63]) begin
            ca[i] = b[i];
            cb[i] = a[i];
          end
        end
      end
      default: begin
        for (int i = 0; i < len; i++) begin
          d = next_draw();
          if ((d >> 11) < 64'(mut_thr)) ca[i] = ~ca[i];
        end
      end
    endcase
    o.child_a = ca & gm;
    o.child_b = cb & gm;
    o.seed_out = rng_state;
    return o;
  endfunction

  function automatic logic [63:0] rand_genome();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic thr_t pick_threshold(input thr_t nominal);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return ONE;
      2: return TMAX;
      3: return nominal;
      4: return thr_t'({$urandom, $urandom});
      5: return ONE >> $urandom_range(1, 8);
      default: return thr_t'({$urandom, $urandom}) >> 1;
    endcase
  endfunction

  function automatic gcm_in_t rand_request();
    gcm_in_t r;
    r.op = 2'($urandom_range(0, 3));
    r.parent_a = rand_genome();
    r.parent_b = rand_genome();
    r.load_seed = ($urandom_range(0, 7) == 0);
    r.seed_value = rand_genome();
    return r;
  endfunction

  // Present one request, hold it until taken, then maybe open a gap
  task automatic send(input gcm_in_t r, input logic known,
                      input logic [63:0] ca, input logic [63:0] cb);
    gcm_out_t want;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    want = recombine(r);
    if (known) begin
      want.child_a = ca;
      want.child_b = cb;
    end
    pending_children.push_back(want);
    op_seen[r.op]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 20))
        @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Hold off new requests until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_children.size() != 0);
    repeat (2) @(posedge clk);
    burst_left = $urandom_range(0, 10);
  endtask

  // Write all three registers; junk fills the unused bits of the length write
  task automatic apply_config(input logic [6:0] glen, input thr_t cx, input thr_t mut,
                              input logic junk);
    cfg_data_t hi;
    hi = junk ? cfg_data_t'({$urandom, $urandom}) : '0;
    cfg_we <= 1'b1;
    cfg_idx <= CFG_GENOME_LENGTH;
    cfg_wdata <= {hi[53:7], glen};
    @(posedge clk);
    cfg_idx <= CFG_CX_THRESHOLD;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_idx <= CFG_MUT_THRESHOLD;
    cfg_wdata <= mut;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_reg = glen;
    cx_thr = cx;
    mut_thr = mut;
    cfg_sets++;
  endtask

  // Receiver: runs of steady ready, long stalls, and short random toggling
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          out_ready <= 1'b1;
          ready_left <= $urandom_range(1, 100);
        end
        3: begin
          out_ready <= 1'b0;
          ready_left <= $urandom_range(1, 80);
        end
        default: begin
          out_ready <= 1'($urandom_range(0, 1));
          ready_left <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    gcm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_children.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = pending_children.pop_front();
        results_seen++;
        if (out_data.child_a !== want.child_a) begin
          $error("child_a mismatch: expected %h, got %h", want.child_a, out_data.child_a);
          fail_count++;
        end
        if (out_data.child_b !== want.child_b) begin
          $error("child_b mismatch: expected %h, got %h", want.child_b, out_data.child_b);
          fail_count++;
        end
        if (out_data.seed_out !== want.seed_out) begin
          $error("seed_out mismatch: expected %h, got %h", want.seed_out, out_data.seed_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int rnd_sent;
    int phase;
    rnd_sent = 0;
    phase = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed list; registers change only when a row asks for a new setting
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].glen != len_reg || dir_rows[i].cx != cx_thr ||
          dir_rows[i].mut != mut_thr) begin
        drain();
        apply_config(dir_rows[i].glen, dir_rows[i].cx, dir_rows[i].mut, 1'b0);
      end
      send(dir_rows[i].req, dir_rows[i].known, dir_rows[i].ca, dir_rows[i].cb);
    end

    // Random phases: mostly short genomes, every sixth phase a long one
    while (rnd_sent < NUM_RANDOM) begin
      logic [6:0] glen;
      int n;
      drain();
      if (phase % 6 == 0) begin
        glen = (phase == 0) ? 7'd64 : 7'($urandom_range(40, 127));
        n = 30;
      end else begin
        glen = 7'($urandom_range(0, 20));
        n = 100;
      end
      apply_config(glen, pick_threshold(RCX), pick_threshold(RMUT), 1'b1);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 199) == 0) drain();
        send(rand_request(), 1'b0, '0, '0);
        rnd_sent++;
      end
      phase++;
    end

    // Let the last results out, then watch for strays
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_children.size() != 0);
    repeat (1000) @(posedge clk);

    $display("Sent %0d requests (%0d directed) across %0d register settings, %0d results checked.",
             NUM_DIR + rnd_sent, NUM_DIR, cfg_sets, results_seen);
    $display("Ops: single-point %0d, two-point %0d, uniform %0d, mutate %0d.",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== genome_crossover_mutation.f =====
design/gcm_pkg.sv
design/gcm_mod.sv
design/gcm_rng.sv
design/genome_crossover_mutation.sv
dv/tb.sv
